[hw/rtl/bdq_pkg.sv]
// Shared constants, codes, command and status types for the bounded deque.
`default_nettype none

package bdq_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam int DATA_W        = 32;
  localparam int MODE_W        = 3;
  localparam int ENTRY_COUNT_W = 5;
  localparam int STATUS_W      = 2;

  typedef logic [MODE_W-1:0]              mode_t;
  typedef logic [STATUS_W-1:0]            status_t;
  typedef logic signed [WORD_WIDTH-1:0]   word_t;
  typedef logic signed [DATA_W-1:0]       data_t;
  typedef logic [IDX_W-1:0]               idx_t;
  typedef logic [CNT_W-1:0]               cnt_t;
  typedef logic [ENTRY_COUNT_W-1:0]       entry_count_t;

  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_BACK  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_BACK   = 3'd3;
  localparam mode_t MODE_CONTAINS   = 3'd4;
  localparam mode_t MODE_REMOVE     = 3'd5;
  localparam mode_t MODE_QUERY      = 3'd6;

  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  // Read address source for the entry RAM
  typedef enum logic [1:0] {
    RD_WALK,
    RD_HEAD,
    RD_TAIL
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    rej_full;
    logic    rej_empty;
    logic    walk_init;
    logic    walk_from_hit;
    logic    walk_step;
    logic    shift_wr;
    logic    mark_found;
    logic    shrink;
    rd_sel_t rd_sel;
    logic    cap_front;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  empty;
    logic  full;
    logic  pend;
    logic  hit;
    logic  miss;
    logic  walk_done;
    logic  out_free;
  } stat_t;

  // Cut an input word to the stored width (sign kept)
  function automatic word_t to_word(data_t d);
    return word_t'(d);
  endfunction

  // Bring a stored word back to the 32-bit result field
  function automatic data_t to_data(word_t w);
    return data_t'(w);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/bdq_datapath.sv]
// Deque datapath: ring pointers, entry RAM, walk logic and result registers.
`default_nettype none

module bdq_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  bdq_pkg::cmd_t         cmd,
  output bdq_pkg::stat_t        st,
  input  bdq_pkg::mode_t        mode,
  input  bdq_pkg::data_t        data_word,
  input  logic                  out_stall,
  output logic                  out_valid,
  output bdq_pkg::data_t        front_word,
  output bdq_pkg::data_t        back_word,
  output bdq_pkg::entry_count_t entry_count,
  output logic                  is_empty,
  output logic                  found,
  output bdq_pkg::status_t      status
);

  import bdq_pkg::*;

  idx_t    head;
  cnt_t    count;
  mode_t   op_mode;
  word_t   op_data;
  cnt_t    ptr;
  cnt_t    chk_idx;
  logic    pend;
  logic    found_r;
  status_t status_r;
  word_t   front_r;

  idx_t  head_dec;
  idx_t  head_inc;
  cnt_t  tail_off;
  cnt_t  shift_dst;
  logic  eq;
  logic  empty;
  logic  we;
  idx_t  waddr;
  word_t wdata;
  idx_t  raddr;
  word_t rdata;

  function automatic idx_t slot(idx_t h, cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(h) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return IDX_W'(sum);
  endfunction

  assign head_dec  = (head == '0) ? idx_t'(DEPTH - 1) : head - idx_t'(1);
  assign head_inc  = (head == idx_t'(DEPTH - 1)) ? '0 : head + idx_t'(1);
  assign empty     = (count == '0);
  assign tail_off  = empty ? '0 : count - cnt_t'(1);
  assign shift_dst = chk_idx - cnt_t'(1);
  assign eq        = (rdata == op_data);

  always_comb begin
    case (cmd.rd_sel)
      RD_WALK: raddr = slot(head, ptr);
      RD_HEAD: raddr = head;
      RD_TAIL: raddr = slot(head, tail_off);
      default: raddr = head;
    endcase
  end

  assign we    = cmd.push_front | cmd.push_back | cmd.shift_wr;
  assign wdata = cmd.shift_wr ? rdata : op_data;

  always_comb begin
    if (cmd.push_front) begin
      waddr = head_dec;
    end else if (cmd.push_back) begin
      waddr = slot(head, count);
    end else begin
      waddr = slot(head, shift_dst);
    end
  end

  bdq_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    st.mode      = op_mode;
    st.empty     = empty;
    st.full      = (count >= cnt_t'(DEPTH));
    st.pend      = pend;
    st.hit       = pend & eq;
    st.miss      = pend & ~eq & (ptr == count);
    st.walk_done = ~pend & (ptr >= count);
    st.out_free  = ~out_valid | ~out_stall;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push_front) begin
        head  <= head_dec;
        count <= count + cnt_t'(1);
      end else if (cmd.push_back) begin
        count <= count + cnt_t'(1);
      end else if (cmd.pop_front) begin
        head  <= head_inc;
        count <= count - cnt_t'(1);
      end else if (cmd.pop_back || cmd.shrink) begin
        count <= count - cnt_t'(1);
      end
      if (cmd.walk_init) begin
        pend <= 1'b0;
      end else if (cmd.walk_step) begin
        pend <= (ptr < count);
      end
      out_valid <= cmd.out_load | (out_valid & out_stall);
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= mode;
      op_data  <= to_word(data_word);
      found_r  <= 1'b0;
      status_r <= STATUS_DONE;
    end
    if (cmd.rej_full) begin
      status_r <= STATUS_FULL;
    end
    if (cmd.rej_empty) begin
      status_r <= STATUS_EMPTY;
    end
    if (cmd.mark_found) begin
      found_r <= 1'b1;
    end
    if (cmd.walk_init) begin
      ptr <= cmd.walk_from_hit ? chk_idx + cnt_t'(1) : '0;
    end else if (cmd.walk_step) begin
      chk_idx <= ptr;
      if (ptr < count) begin
        ptr <= ptr + cnt_t'(1);
      end
    end
    if (cmd.cap_front) begin
      front_r <= rdata;
    end
    if (cmd.out_load) begin
      front_word  <= empty ? '0 : to_data(front_r);
      back_word   <= empty ? '0 : to_data(rdata);
      entry_count <= ENTRY_COUNT_W'(count);
      is_empty    <= empty;
      found       <= found_r;
      status      <= status_r;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(DEPTH))
    else $error("entry count beyond depth");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while held");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_front || cmd.push_back) |=> (count == $past(count) + cnt_t'(1)))
    else $error("push did not grow count");

  a_shift_src: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> (pend && chk_idx != '0))
    else $error("shift write without returned entry");
`endif

endmodule

`default_nettype wire

[hw/rtl/bdq_ctrl.sv]
// Deque controller: sequences decode, search walk, shift and read-back.
`default_nettype none

module bdq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bdq_pkg::stat_t st,
  output bdq_pkg::cmd_t  cmd
);

  import bdq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_RD_FRONT = 3'd4;
  localparam logic [2:0] S_RD_BACK  = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_WALK;
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_RD_FRONT;
        unique case (st.mode) inside
          MODE_PUSH_FRONT: begin
            if (st.full) cmd.rej_full = 1'b1;
            else         cmd.push_front = 1'b1;
          end
          MODE_PUSH_BACK: begin
            if (st.full) cmd.rej_full = 1'b1;
            else         cmd.push_back = 1'b1;
          end
          MODE_POP_FRONT: begin
            if (st.empty) cmd.rej_empty = 1'b1;
            else          cmd.pop_front = 1'b1;
          end
          MODE_POP_BACK: begin
            if (st.empty) cmd.rej_empty = 1'b1;
            else          cmd.pop_back = 1'b1;
          end
          MODE_CONTAINS, MODE_REMOVE: begin
            if (st.empty) begin
              cmd.rej_empty = 1'b1;
            end else begin
              cmd.walk_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (st.hit) begin
          cmd.mark_found = 1'b1;
          if (st.mode == MODE_REMOVE) begin
            cmd.walk_init     = 1'b1;
            cmd.walk_from_hit = 1'b1;
            state_next        = S_SHIFT;
          end else begin
            state_next = S_RD_FRONT;
          end
        end else begin
          cmd.walk_step = 1'b1;
          if (st.miss) begin
            state_next = S_RD_FRONT;
          end
        end
      end
      S_SHIFT: begin
        if (st.walk_done) begin
          cmd.shrink = 1'b1;
          state_next = S_RD_FRONT;
        end else begin
          cmd.walk_step = 1'b1;
          cmd.shift_wr  = st.pend;
        end
      end
      S_RD_FRONT: begin
        cmd.rd_sel = RD_HEAD;
        state_next = S_RD_BACK;
      end
      S_RD_BACK: begin
        cmd.rd_sel    = RD_TAIL;
        cmd.cap_front = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        cmd.rd_sel = RD_TAIL;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/bounded_deque_with_search.sv]
// Top level of the bounded deque with search: controller plus datapath.
// Push, pop and query pass from the accepted beat through decode, front read, back
// read and finish; the result register loads in finish once free. Contains adds a
// search walk, remove a walk and a shift, one stored entry per cycle through the single
// read port of the entry RAM. Reset clears head index, count and all handshake state;
// RAM contents are left as they are, with no clearing pass.
`default_nettype none

module bounded_deque_with_search (
  input  logic                  clk,
  input  logic                  rst,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bdq_pkg::mode_t        mode,
  input  bdq_pkg::data_t        data_word,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output bdq_pkg::data_t        front_word,
  output bdq_pkg::data_t        back_word,
  output bdq_pkg::entry_count_t entry_count,
  output logic                  is_empty,
  output logic                  found,
  output bdq_pkg::status_t      status
);

  import bdq_pkg::*;

  // Commands flow from the controller to the datapath; status flows back.
  cmd_t  cmd;
  stat_t st;

  // The controller takes one beat at a time: it lowers in_stall only while idle,
  // walks the stored entries for contains and remove, closes the gap on a remove
  // by moving later entries one place toward the front, then reads back the front
  // and back entries before loading the result register.
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the ring pointers, the entry RAM and the result register.
  // The result register frees on its own handshake, so a finished result may sit
  // while the next beat is accepted and worked on; the controller only waits at
  // the final load if that earlier result is still held.
  bdq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .mode        (mode),
    .data_word   (data_word),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .front_word  (front_word),
    .back_word   (back_word),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .found       (found),
    .status      (status)
  );

endmodule

`default_nettype wire
